// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is asserted
`define MSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that must also hold during reset
`define MSE_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/macd_se_pkg.sv =====
package macd_se_pkg;

  localparam int PRICE_BITS     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int COUNT_BITS     = 8;
  localparam int PERIOD_BITS    = 8;
  localparam int ALPHA_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam int AVG_BITS   = PRICE_BITS + FRAC_BITS;
  localparam int OUT_BITS   = AVG_BITS + 1;
  localparam int DIFF_BITS  = OUT_BITS + 1;
  localparam int LO_BITS    = (DIFF_BITS > 33) ? 32 : DIFF_BITS - 1;
  localparam int HI_BITS    = DIFF_BITS - LO_BITS;
  localparam int MUL_BITS   = (LO_BITS + 1 > HI_BITS) ? LO_BITS + 1 : HI_BITS;
  localparam int PROD_BITS  = MUL_BITS + ALPHA_BITS + 1;
  localparam int SHIFT_BITS = LO_BITS - ALPHA_BITS;
  localparam int CMP_BITS   = (COUNT_BITS + 1 > PERIOD_BITS) ? COUNT_BITS + 1 : PERIOD_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [PERIOD_BITS-1:0] FAST_PERIOD_RST   = PERIOD_BITS'(12);
  localparam logic [PERIOD_BITS-1:0] SLOW_PERIOD_RST   = PERIOD_BITS'(26);
  localparam logic [PERIOD_BITS-1:0] SIGNAL_PERIOD_RST = PERIOD_BITS'(9);
  localparam logic [ALPHA_BITS-1:0]  FAST_ALPHA_RST    = ALPHA_BITS'(10082);
  localparam logic [ALPHA_BITS-1:0]  SLOW_ALPHA_RST    = ALPHA_BITS'(4855);
  localparam logic [ALPHA_BITS-1:0]  SIGNAL_ALPHA_RST  = ALPHA_BITS'(13107);

  localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_PERIOD   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_PERIOD   = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNAL_PERIOD = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_ALPHA    = CFG_INDEX_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_ALPHA    = CFG_INDEX_BITS'(4);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNAL_ALPHA  = CFG_INDEX_BITS'(5);

  typedef enum logic [1:0] {
    LANE_FAST,
    LANE_SLOW,
    LANE_SIGNAL
  } lane_e;

  typedef struct packed {
    logic  capture;
    logic  diff_load;
    logic  mul_lo;
    logic  mul_hi;
    logic  avg_upd;
    lane_e lane;
    logic  macd_load;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic macd_ok;
    logic out_free;
  } status_t;

endpackage

// ===== src/macd_se_ctrl.sv =====
module macd_se_ctrl
  import macd_se_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_F_D  = 4'd1;
  localparam logic [3:0] ST_F_L  = 4'd2;
  localparam logic [3:0] ST_F_H  = 4'd3;
  localparam logic [3:0] ST_F_U  = 4'd4;
  localparam logic [3:0] ST_S_D  = 4'd5;
  localparam logic [3:0] ST_S_L  = 4'd6;
  localparam logic [3:0] ST_S_H  = 4'd7;
  localparam logic [3:0] ST_S_U  = 4'd8;
  localparam logic [3:0] ST_MACD = 4'd9;
  localparam logic [3:0] ST_G_D  = 4'd10;
  localparam logic [3:0] ST_G_L  = 4'd11;
  localparam logic [3:0] ST_G_H  = 4'd12;
  localparam logic [3:0] ST_G_U  = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.lane = LANE_FAST;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_F_D;
        end
      end
      ST_F_D: begin
        cmd_o.diff_load = 1'b1;
        state_d         = ST_F_L;
      end
      ST_F_L: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_F_H;
      end
      ST_F_H: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_F_U;
      end
      ST_F_U: begin
        cmd_o.avg_upd = 1'b1;
        state_d       = ST_S_D;
      end
      ST_S_D: begin
        cmd_o.lane      = LANE_SLOW;
        cmd_o.diff_load = 1'b1;
        state_d         = ST_S_L;
      end
      ST_S_L: begin
        cmd_o.lane   = LANE_SLOW;
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_S_H;
      end
      ST_S_H: begin
        cmd_o.lane   = LANE_SLOW;
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_S_U;
      end
      ST_S_U: begin
        cmd_o.lane    = LANE_SLOW;
        cmd_o.avg_upd = 1'b1;
        state_d       = ST_MACD;
      end
      ST_MACD: begin
        cmd_o.macd_load = 1'b1;
        state_d         = status_i.macd_ok ? ST_G_D : ST_DONE;
      end
      ST_G_D: begin
        cmd_o.lane      = LANE_SIGNAL;
        cmd_o.diff_load = 1'b1;
        state_d         = ST_G_L;
      end
      ST_G_L: begin
        cmd_o.lane   = LANE_SIGNAL;
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_G_H;
      end
      ST_G_H: begin
        cmd_o.lane   = LANE_SIGNAL;
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_G_U;
      end
      ST_G_U: begin
        cmd_o.lane    = LANE_SIGNAL;
        cmd_o.avg_upd = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/macd_se_datapath.sv =====
module macd_se_datapath
  import macd_se_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cmd_t                             cmd_i,
  output status_t                          status_o,
  input  logic                             cfg_valid_i,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data_i,
  input  logic [PRICE_BITS-1:0]            price_i,
  input  logic                             series_start_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [OUT_BITS-1:0]       macd_value_o,
  output logic signed [OUT_BITS-1:0]       signal_value_o,
  output logic signed [OUT_BITS-1:0]       histogram_value_o,
  output logic                             macd_valid_o,
  output logic                             signal_valid_o
);

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  function automatic logic [CMP_BITS-1:0] eff_period(input logic [PERIOD_BITS-1:0] p);
    return (p == '0) ? CMP_BITS'(1) : CMP_BITS'(p);
  endfunction

  function automatic logic [CMP_BITS-1:0] pos_of(input logic [COUNT_BITS-1:0] idx);
    return CMP_BITS'(idx) + CMP_BITS'(1);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_BITS'(1);
  endfunction

  // configuration registers
  logic [PERIOD_BITS-1:0] fast_period_q, slow_period_q, signal_period_q;
  logic [ALPHA_BITS-1:0]  fast_alpha_q, slow_alpha_q, signal_alpha_q;

  // running state
  logic [COUNT_BITS-1:0]      sample_count_q, macd_count_q;
  logic [COUNT_BITS-1:0]      idx_q, midx_q;
  logic [AVG_BITS-1:0]        fast_q, slow_q;
  logic signed [OUT_BITS-1:0] sig_q, macd_q;
  logic                       mv_q, gv_q;
  logic [AVG_BITS-1:0]        x_q;

  // shared arithmetic
  logic signed [DIFF_BITS-1:0]     d_q;
  logic signed [PROD_BITS-1:0]     prod_q, prod_d;
  logic [LO_BITS+ALPHA_BITS-1:0]   lo_q;
  logic signed [MUL_BITS-1:0]      mul_a;
  logic signed [ALPHA_BITS:0]      alpha_s;
  logic [PROD_BITS+SHIFT_BITS-1:0] hp_shift;
  logic signed [DIFF_BITS-1:0]     step, new_avg, diff_d;

  logic signed [DIFF_BITS-1:0] lane_avg, lane_x;
  logic [COUNT_BITS-1:0]       lane_idx;
  logic [PERIOD_BITS-1:0]      lane_period;
  logic [ALPHA_BITS-1:0]       lane_alpha;
  logic                        lane_seed, lane_upd;
  logic                        fast_ok, slow_ok;
  logic [COUNT_BITS-1:0]       idx_next;

  // output stage
  logic signed [DIFF_BITS-1:0] hist_full;
  logic signed [OUT_BITS-1:0]  hist_sat;
  logic                        out_valid_q;
  logic signed [OUT_BITS-1:0]  out_macd_q, out_sig_q, out_hist_q;
  logic                        out_mv_q, out_gv_q;

  always_comb begin
    unique case (cmd_i.lane)
      LANE_FAST: begin
        lane_avg    = DIFF_BITS'(fast_q);
        lane_x      = DIFF_BITS'(x_q);
        lane_idx    = idx_q;
        lane_period = fast_period_q;
        lane_alpha  = fast_alpha_q;
      end
      LANE_SLOW: begin
        lane_avg    = DIFF_BITS'(slow_q);
        lane_x      = DIFF_BITS'(x_q);
        lane_idx    = idx_q;
        lane_period = slow_period_q;
        lane_alpha  = slow_alpha_q;
      end
      LANE_SIGNAL: begin
        lane_avg    = DIFF_BITS'(sig_q);
        lane_x      = DIFF_BITS'(macd_q);
        lane_idx    = midx_q;
        lane_period = signal_period_q;
        lane_alpha  = signal_alpha_q;
      end
      default: begin
        lane_avg    = DIFF_BITS'(fast_q);
        lane_x      = DIFF_BITS'(x_q);
        lane_idx    = idx_q;
        lane_period = fast_period_q;
        lane_alpha  = fast_alpha_q;
      end
    endcase
  end

  assign lane_seed = pos_of(lane_idx) == eff_period(lane_period);
  assign lane_upd  = pos_of(lane_idx) > eff_period(lane_period);
  assign fast_ok   = pos_of(idx_q) >= eff_period(fast_period_q);
  assign slow_ok   = pos_of(idx_q) >= eff_period(slow_period_q);
  assign diff_d    = lane_x - lane_avg;
  assign idx_next  = series_start_i ? '0 : sample_count_q;

  // difference split into an unsigned low word and a signed high word
  always_comb begin
    if (cmd_i.mul_hi) begin
      mul_a = MUL_BITS'($signed(d_q[DIFF_BITS-1:LO_BITS]));
    end else begin
      mul_a = MUL_BITS'({1'b0, d_q[LO_BITS-1:0]});
    end
  end

  assign alpha_s  = {1'b0, lane_alpha};
  assign prod_d   = mul_a * alpha_s;
  assign hp_shift = {prod_q, {SHIFT_BITS{1'b0}}};
  assign step     = hp_shift[DIFF_BITS-1:0]
                  + DIFF_BITS'(lo_q[LO_BITS+ALPHA_BITS-1:ALPHA_BITS]);
  assign new_avg  = lane_avg + step;

  assign hist_full = DIFF_BITS'(macd_q) - DIFF_BITS'(sig_q);
  always_comb begin
    if (hist_full[DIFF_BITS-1] != hist_full[DIFF_BITS-2]) begin
      hist_sat = hist_full[DIFF_BITS-1] ? OUT_MIN : OUT_MAX;
    end else begin
      hist_sat = hist_full[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_period_q   <= FAST_PERIOD_RST;
      slow_period_q   <= SLOW_PERIOD_RST;
      signal_period_q <= SIGNAL_PERIOD_RST;
      fast_alpha_q    <= FAST_ALPHA_RST;
      slow_alpha_q    <= SLOW_ALPHA_RST;
      signal_alpha_q  <= SIGNAL_ALPHA_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FAST_PERIOD:   fast_period_q   <= cfg_data_i[PERIOD_BITS-1:0];
        REG_SLOW_PERIOD:   slow_period_q   <= cfg_data_i[PERIOD_BITS-1:0];
        REG_SIGNAL_PERIOD: signal_period_q <= cfg_data_i[PERIOD_BITS-1:0];
        REG_FAST_ALPHA:    fast_alpha_q    <= cfg_data_i[ALPHA_BITS-1:0];
        REG_SLOW_ALPHA:    slow_alpha_q    <= cfg_data_i[ALPHA_BITS-1:0];
        REG_SIGNAL_ALPHA:  signal_alpha_q  <= cfg_data_i[ALPHA_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= '0;
      macd_count_q   <= '0;
      idx_q          <= '0;
      midx_q         <= '0;
      fast_q         <= '0;
      slow_q         <= '0;
      sig_q          <= '0;
      mv_q           <= 1'b0;
      gv_q           <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_q          <= idx_next;
        sample_count_q <= sat_inc(idx_next);
        if (series_start_i) begin
          macd_count_q <= '0;
        end
      end else if (cmd_i.macd_load) begin
        mv_q <= fast_ok && slow_ok;
        gv_q <= 1'b0;
        if (fast_ok && slow_ok) begin
          midx_q       <= macd_count_q;
          macd_count_q <= sat_inc(macd_count_q);
        end
      end
      if (cmd_i.avg_upd) begin
        unique case (cmd_i.lane)
          LANE_FAST: begin
            if (lane_seed) begin
              fast_q <= lane_x[AVG_BITS-1:0];
            end else if (lane_upd) begin
              fast_q <= new_avg[AVG_BITS-1:0];
            end
          end
          LANE_SLOW: begin
            if (lane_seed) begin
              slow_q <= lane_x[AVG_BITS-1:0];
            end else if (lane_upd) begin
              slow_q <= new_avg[AVG_BITS-1:0];
            end
          end
          LANE_SIGNAL: begin
            gv_q <= lane_seed || lane_upd;
            if (lane_seed) begin
              sig_q <= lane_x[OUT_BITS-1:0];
            end else if (lane_upd) begin
              sig_q <= new_avg[OUT_BITS-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= {price_i, {FRAC_BITS{1'b0}}};
    end
    if (cmd_i.macd_load) begin
      macd_q <= $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
    end
    if (cmd_i.diff_load) begin
      d_q <= diff_d;
    end
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_hi) begin
      lo_q <= prod_q[LO_BITS+ALPHA_BITS-1:0];
    end
    if (cmd_i.out_load) begin
      out_macd_q <= mv_q ? macd_q : '0;
      out_sig_q  <= gv_q ? sig_q : '0;
      out_hist_q <= gv_q ? hist_sat : '0;
      out_mv_q   <= mv_q;
      out_gv_q   <= gv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.macd_ok  = fast_ok && slow_ok;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign macd_value_o      = out_macd_q;
  assign signal_value_o    = out_sig_q;
  assign histogram_value_o = out_hist_q;
  assign macd_valid_o      = out_mv_q;
  assign signal_valid_o    = out_gv_q;

endmodule

// ===== src/macd_signal_engine.sv =====
// MACD engine: one unsigned price per request in, one result per request out (macd,
// signal, histogram in signed Q32.16 plus two valid flags). Each request runs the
// fast and slow average updates and the macd load, then the signal update only if
// the macd is valid; its result is loaded once the output register is free, and the
// next request is accepted only after that load. The rate is set by the
// one shared multiplier (about 33 by 17 bits), which every exponential average passes
// through twice per update, low and high word of the difference. A finished result sits
// in an output register, so the next price is taken while it waits. Configuration writes
// are always accepted and take effect at once; write them only while no request is in
// flight.
module macd_signal_engine
  import macd_se_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [PRICE_BITS-1:0]      price_i,
  input  logic                       series_start_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_BITS-1:0] macd_value_o,
  output logic signed [OUT_BITS-1:0] signal_value_o,
  output logic signed [OUT_BITS-1:0] histogram_value_o,
  output logic                       macd_valid_o,
  output logic                       signal_valid_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  macd_se_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  macd_se_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .price_i           (price_i),
    .series_start_i    (series_start_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .macd_value_o      (macd_value_o),
    .signal_value_o    (signal_value_o),
    .histogram_value_o (histogram_value_o),
    .macd_valid_o      (macd_valid_o),
    .signal_valid_o    (signal_valid_o)
  );

endmodule

// ===== src/macd_se_checker.sv =====
`include "assert_macros.svh"

module macd_se_checker
  import macd_se_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [OUT_BITS-1:0] macd_value_o,
  input logic signed [OUT_BITS-1:0] signal_value_o,
  input logic signed [OUT_BITS-1:0] histogram_value_o,
  input logic                       macd_valid_o,
  input logic                       signal_valid_o
);

  // one request in flight at a time
  `MSE_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "input accepted while busy")

  // a result needs work after the accept before it can appear
  `MSE_ASSERT(a_no_early_result, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !$rose(out_valid_o), "result appeared right after accept")

  `MSE_ASSERT_NR(a_signal_needs_macd, clk_i, out_valid_o |-> (macd_valid_o || !signal_valid_o), "signal valid without macd valid")

  // unseeded values read as zero
  `MSE_ASSERT_NR(a_masked_zero, clk_i, (out_valid_o && !macd_valid_o) |-> (macd_value_o == '0 && signal_value_o == '0 && histogram_value_o == '0), "unseeded result not zero")

  `MSE_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(macd_value_o) && $stable(histogram_value_o)), "stalled result changed")

endmodule

bind macd_signal_engine macd_se_checker u_macd_se_checker (.*);
